// ----- rtl/mnpct_pkg.sv -----
// ----------------------------------------------------------------------------
// mnpct_pkg
// Shared types, constants and helpers of the MIDI note pitch-class tracker.
// ----------------------------------------------------------------------------
package mnpct_pkg;

    localparam int NOTE_SLOTS  = 128;
    localparam int NOTE_W      = 7;
    localparam int CLASS_SLOTS = 12;
    localparam int CLASS_W     = 4;
    localparam int CTL_W       = 7;
    localparam int HELD_W      = 8;

    localparam logic [CTL_W-1:0] CC_ALL_NOTES_OFF = 7'd123;
    localparam logic [CTL_W-1:0] CC_ALL_SOUND_OFF = 7'd120;

    typedef enum logic [2:0] {
        CMD_BLOCK_START = 3'd0,
        CMD_NOTE_ON     = 3'd1,
        CMD_NOTE_OFF    = 3'd2,
        CMD_CONTROLLER  = 3'd3,
        CMD_OTHER       = 3'd4
    } t_cmd;

    typedef struct packed {
        logic              wr_en;
        logic              clr;
        logic [NOTE_W-1:0] wr_addr;
    } t_store_ctrl;

    // note mod 12 via reciprocal multiply: q = (n * 43) >> 9 is exact for n < 128
    function automatic logic [CLASS_W-1:0] f_pitch_class(input logic [NOTE_W-1:0] n);
        logic [12:0]       prod;
        logic [3:0]        q;
        logic [NOTE_W-1:0] base;
        prod = 13'(n) * 13'd43;
        q    = prod[12:9];
        base = 7'(q) * 7'd12;
        return CLASS_W'(n - base);
    endfunction

endpackage

// ----- rtl/mnpct_note_store.sv -----
// ----------------------------------------------------------------------------
// mnpct_note_store
// Per-note held counts: one write and one registered read per cycle, with
// write-to-read bypass and per-entry valid bits for clearing every entry at once.
// ----------------------------------------------------------------------------
module mnpct_note_store #(
    parameter int COUNT_WIDTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [mnpct_pkg::NOTE_W-1:0]  i_rd_addr,
    input  mnpct_pkg::t_store_ctrl        i_ctrl,
    input  logic [COUNT_WIDTH-1:0]        i_wr_data,
    output logic [COUNT_WIDTH-1:0]        o_rd_data
);

    logic [COUNT_WIDTH-1:0]               r_mem [mnpct_pkg::NOTE_SLOTS];
    logic [mnpct_pkg::NOTE_SLOTS-1:0]     r_valid;
    logic [COUNT_WIDTH-1:0]               r_rd_data;
    logic [mnpct_pkg::NOTE_W-1:0]         r_rd_addr;
    logic                                 r_hit;
    logic [COUNT_WIDTH-1:0]               r_byp;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_ctrl.wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
            r_byp     <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit   <= 1'b0;
        end else begin
            if (i_ctrl.clr) begin
                r_valid <= '0;
            end else if (i_ctrl.wr_en) begin
                r_valid[i_ctrl.wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_hit <= i_ctrl.wr_en && (i_ctrl.wr_addr == i_rd_addr);
            end
        end
    end

    assign o_rd_data = r_hit               ? r_byp     :
                       r_valid[r_rd_addr]  ? r_rd_data : '0;

endmodule

// ----- rtl/midi_note_pitch_class_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// midi_note_pitch_class_tracker_unit
// Held-note and pitch-class counter for classified MIDI events and transport
// samples; one result per input transfer.
// ----------------------------------------------------------------------------
// Takes one event per cycle unless the output stalls, and returns one result
// per event; each result passes through the registered read of the per-note
// count store and then the result register. Counts clear at once on a rising
// edge of the playing flag, with no sweep after reset. Write the freeze register
// only while no result is outstanding.
module midi_note_pitch_class_tracker_unit #(
    parameter int COUNT_WIDTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // note_number[6:0], controller_number[13:7],
                                        // is_playing[14], zero[15]
    input  logic [2:0]  s_axis_tuser,   // command[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // class_mask[11:0], note_held[19:12],
                                        // class_held[27:20], paused[28], zero[31:29]
    output logic        m_axis_tuser    // passed_on
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                                 r_freeze;
    logic                                 r_was_running;
    logic                                 r_pause;
    logic [COUNT_WIDTH-1:0]               r_class [mnpct_pkg::CLASS_SLOTS];

    logic                                 r_s1_valid;
    mnpct_pkg::t_cmd                      r_cmd;
    logic [mnpct_pkg::NOTE_W-1:0]         r_note;
    logic [mnpct_pkg::CLASS_W-1:0]        r_pc;
    logic [mnpct_pkg::CTL_W-1:0]          r_ctl;
    logic                                 r_play;

    logic                                 r_out_valid;
    logic                                 r_out_passed;
    logic [mnpct_pkg::CLASS_SLOTS-1:0]    r_out_mask;
    logic [mnpct_pkg::HELD_W-1:0]         r_out_note;
    logic [mnpct_pkg::HELD_W-1:0]         r_out_class;
    logic                                 r_out_paused;

    logic                                 w_accept;
    logic                                 w_adv;
    logic                                 w_suppress;
    logic [COUNT_WIDTH-1:0]               w_note_cur;
    logic [COUNT_WIDTH-1:0]               w_class_cur;
    logic [COUNT_WIDTH-1:0]               n_note;
    logic [COUNT_WIDTH-1:0]               n_class_sel;
    logic [COUNT_WIDTH-1:0]               n_class [mnpct_pkg::CLASS_SLOTS];
    logic [mnpct_pkg::CLASS_SLOTS-1:0]    n_mask;
    logic                                 n_passed;
    logic                                 n_pause;
    logic                                 n_was_running;
    logic                                 n_write;
    logic                                 n_clear;
    mnpct_pkg::t_store_ctrl               w_ctrl;

    assign w_adv         = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_suppress    = r_freeze || r_pause;
    assign w_class_cur   = r_class[r_pc];

    assign w_ctrl.wr_en   = w_adv && n_write;
    assign w_ctrl.clr     = w_adv && n_clear;
    assign w_ctrl.wr_addr = r_note;

    mnpct_note_store #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_note_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (s_axis_tdata[6:0]),
        .i_ctrl    (w_ctrl),
        .i_wr_data (n_note),
        .o_rd_data (w_note_cur)
    );

    always_comb begin
        n_note        = w_note_cur;
        n_class_sel   = w_class_cur;
        n_passed      = 1'b1;
        n_pause       = r_pause;
        n_was_running = r_was_running;
        n_write       = 1'b0;
        n_clear       = 1'b0;
        case (r_cmd)
            mnpct_pkg::CMD_BLOCK_START: begin
                n_passed      = 1'b0;
                n_was_running = r_play;
                if (r_was_running && !r_play) begin
                    n_pause = 1'b1;
                end else if (!r_was_running && r_play) begin
                    n_pause = 1'b0;
                    n_clear = 1'b1;
                end
            end
            mnpct_pkg::CMD_NOTE_ON: begin
                n_write = 1'b1;
                if (w_note_cur != COUNT_MAX) begin
                    n_note = w_note_cur + COUNT_WIDTH'(1);
                end
                if (w_class_cur != COUNT_MAX) begin
                    n_class_sel = w_class_cur + COUNT_WIDTH'(1);
                end
            end
            mnpct_pkg::CMD_NOTE_OFF: begin
                if (w_suppress) begin
                    n_passed = 1'b0;
                end else begin
                    n_write = 1'b1;
                    if (w_note_cur != '0) begin
                        n_note = w_note_cur - COUNT_WIDTH'(1);
                    end
                    if (w_class_cur != '0) begin
                        n_class_sel = w_class_cur - COUNT_WIDTH'(1);
                    end
                end
            end
            mnpct_pkg::CMD_CONTROLLER: begin
                if (w_suppress && (r_ctl == mnpct_pkg::CC_ALL_NOTES_OFF ||
                                   r_ctl == mnpct_pkg::CC_ALL_SOUND_OFF)) begin
                    n_passed = 1'b0;
                end
            end
            default: begin
                n_passed = 1'b1;
            end
        endcase
        if (n_clear) begin
            n_note      = '0;
            n_class_sel = '0;
        end
        for (int k = 0; k < mnpct_pkg::CLASS_SLOTS; k++) begin
            if (n_clear) begin
                n_class[k] = '0;
            end else if (r_pc == mnpct_pkg::CLASS_W'(k)) begin
                n_class[k] = n_class_sel;
            end else begin
                n_class[k] = r_class[k];
            end
            n_mask[k] = (n_class[k] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= mnpct_pkg::t_cmd'(s_axis_tuser);
            r_note <= s_axis_tdata[6:0];
            r_pc   <= mnpct_pkg::f_pitch_class(s_axis_tdata[6:0]);
            r_ctl  <= s_axis_tdata[13:7];
            r_play <= s_axis_tdata[14];
        end
        if (w_adv) begin
            r_out_passed <= n_passed;
            r_out_mask   <= n_mask;
            r_out_note   <= mnpct_pkg::HELD_W'(n_note);
            r_out_class  <= mnpct_pkg::HELD_W'(n_class_sel);
            r_out_paused <= n_pause;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freeze      <= 1'b0;
            r_was_running <= 1'b0;
            r_pause       <= 1'b0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int k = 0; k < mnpct_pkg::CLASS_SLOTS; k++) begin
                r_class[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_freeze <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid   <= 1'b1;
                r_was_running <= n_was_running;
                r_pause       <= n_pause;
                for (int k = 0; k < mnpct_pkg::CLASS_SLOTS; k++) begin
                    r_class[k] <= n_class[k];
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_passed;
    assign m_axis_tdata  = {3'b000, r_out_paused, r_out_class, r_out_note, r_out_mask};

endmodule
